/* design/cwc_pkg.sv */
// Shared types, window table and constants for the color window classifier.
package cwc_pkg;

  // Result category codes
  typedef enum logic [3:0] {
    CAT_PINK       = 4'd0,
    CAT_ORANGE     = 4'd1,
    CAT_LIGHT_BLUE = 4'd2,
    CAT_RED        = 4'd3,
    CAT_GREEN      = 4'd4,
    CAT_DEFECT     = 4'd5,
    CAT_RETRY      = 4'd6,
    CAT_GAP        = 4'd7,
    CAT_CLEARED    = 4'd8
  } cat_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MATCH,
    ST_FIN
  } state_t;

  // Configuration register indexes
  typedef enum logic {
    REG_MIN_CLEAR   = 1'b0,
    REG_RETRY_LIMIT = 1'b1
  } cfg_reg_t;

  localparam int DIV_W       = 16;
  localparam int NUM_CLASSES = 5;
  localparam int NUM_COUNTS  = 6;
  localparam int NUM_CHAN    = 3;

  localparam logic [15:0] MIN_CLEAR_RST   = 16'd900;
  localparam logic [7:0]  RETRY_LIMIT_RST = 8'd5;

  localparam logic [12:0] SERVO_DEFECT = 13'd2499;
  localparam logic [4:0]  LED_FULL     = 5'd17;
  localparam logic [4:0]  LED_OFF      = 5'd0;

  // clear/100 as (clear * ceil(2^24/100)) >> 24, exact for 16-bit clear
  localparam int          RECIP_W     = 18;
  localparam logic [17:0] RECIP_100   = 18'd167773;
  localparam int          RECIP_SHIFT = 24;
  localparam int          SCALE_W     = 10;

  typedef struct packed {
    logic [5:0]  rlo;
    logic [5:0]  rhi;
    logic [5:0]  glo;
    logic [5:0]  ghi;
    logic [5:0]  blo;
    logic [5:0]  bhi;
    logic [12:0] servo;
    logic [4:0]  dr;
    logic [4:0]  dg;
    logic [4:0]  db;
  } window_t;

  // Tested in order: pink, orange, light blue, red, green
  localparam window_t WINDOWS [NUM_CLASSES] = '{
    '{6'd22, 6'd38, 6'd24, 6'd35, 6'd29, 6'd39, 13'd999,  5'd17, 5'd0,  5'd17},
    '{6'd38, 6'd60, 6'd24, 6'd36, 6'd9,  6'd17, 13'd1999, 5'd17, 5'd1,  5'd0},
    '{6'd14, 6'd29, 6'd34, 6'd42, 6'd34, 6'd43, 13'd2999, 5'd0,  5'd5,  5'd17},
    '{6'd40, 6'd62, 6'd19, 6'd30, 6'd18, 6'd30, 13'd3999, 5'd17, 5'd0,  5'd0},
    '{6'd24, 6'd42, 6'd38, 6'd49, 6'd14, 6'd23, 13'd4999, 5'd17, 5'd17, 5'd0}
  };

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* design/cwc_div.sv */
// Shared radix-4 restoring divider, two quotient bits per cycle.
module cwc_div (
  input  logic            clk,
  input  logic            rst,
  input  cwc_pkg::div_req_t req,
  output cwc_pkg::div_rsp_t rsp
);
  import cwc_pkg::*;

  localparam int STEPS = DIV_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvd;
  logic [DIV_W-1:0] dsr;

  logic [DIV_W:0]   t1, t2;
  logic [DIV_W-1:0] s1, s2;
  logic             q1, q2;

  // Two dependent subtract steps; a zero divisor yields all ones
  always_comb begin
    t1 = {rem, dvd[DIV_W-1]};
    q1 = (t1 >= {1'b0, dsr});
    s1 = q1 ? DIV_W'(t1 - {1'b0, dsr}) : t1[DIV_W-1:0];
    t2 = {s1, dvd[DIV_W-2]};
    q2 = (t2 >= {1'b0, dsr});
    s2 = q2 ? DIV_W'(t2 - {1'b0, dsr}) : t2[DIV_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath; quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= s2;
      dvd <= {dvd[DIV_W-3:0], q1, q2};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = dvd;

  a_start_idle : assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider started while busy");
  a_done_idle : assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  a_done_pulse : assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done longer than one cycle");

endmodule

/* design/color_window_classifier_core.sv */
// Top level: sequencer, class state and stream ports of the color window classifier.
// A color reading runs from the accepting edge to m_tvalid through the scale multiply,
// three 8-step divisions back to back on the shared divider and the window match; gap and
// clear requests go straight to the output stage. Throughput: one request at a time, accepted
// only when idle; the next request waits while m_tready holds off a result.
// Reset (rst, synchronous): counters, retry count and LEDs zero, servo 2499,
// min_clear 900, retry_limit 5, output channel empty.
module color_window_classifier_core #(
  parameter int COUNTER_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // clear_level, red_level, green_level, blue_level
  input  logic [1:0]  s_tuser,   // req_type, jam_recovery
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // servo_pulse, led_red_duty, led_green_duty,
                                 // led_blue_duty, advance, count_pink, count_orange,
                                 // count_light_blue, count_red, count_green,
                                 // count_defect, zero pad
  output logic [3:0]  m_tuser    // category
);
  import cwc_pkg::*;

  // Configuration
  logic [15:0] min_clear;
  logic [7:0]  retry_limit;

  // Class state
  logic [7:0]              retry_count;
  logic [12:0]             servo_position;
  logic [4:0]              led_r, led_g, led_b;
  logic [COUNTER_BITS-1:0] counters [NUM_COUNTS];
  cat_t                    cat;
  logic                    adv;

  // Request latch
  logic [15:0]        clr_r, red_r, grn_r, blu_r;
  logic [SCALE_W-1:0] scale;
  logic [DIV_W-1:0]   pct [NUM_CHAN];
  logic [1:0]         ch;

  state_t state, state_next;
  logic   s_accept;
  logic   div_start;
  logic   out_free;
  logic   ld_out;
  logic   present;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [RECIP_W+15:0] product;
  logic [NUM_CLASSES-1:0] hits;
  logic [2:0]             hit_idx;
  logic                   any_hit;
  logic [76:0]            word;

  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign present  = (s_tdata[15:0] > min_clear) && !s_tuser[1];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_clear   <= MIN_CLEAR_RST;
      retry_limit <= RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_CLEAR:   min_clear   <= cfg_data;
        REG_RETRY_LIMIT: retry_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_accept) begin
          if (s_tuser[0] || !present) state_next = ST_FIN;
          else                        state_next = ST_SCALE;
        end
      end
      ST_SCALE:     state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done && ch == 2'(NUM_CHAN - 1)) state_next = ST_MATCH;
      end
      ST_MATCH: state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    ld_out    = 1'b0;
    unique case (state)
      ST_IDLE:      s_tready  = 1'b1;
      ST_DIV_START: div_start = 1'b1;
      ST_DIV_WAIT:  div_start = div_rsp.done && ch != 2'(NUM_CHAN - 1);
      ST_FIN:       ld_out    = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Divider feed: channel picked by ch, or by ch + 1 on a back-to-back start
  always_comb begin
    div_req.start   = div_start;
    div_req.divisor = DIV_W'(scale);
    case (div_start && state == ST_DIV_WAIT ? ch + 2'd1 : ch)
      2'd0:    div_req.dividend = red_r;
      2'd1:    div_req.dividend = grn_r;
      default: div_req.dividend = blu_r;
    endcase
  end

  cwc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // clear / 100 by reciprocal multiply
  assign product = clr_r * RECIP_100;

  // Request latch, scale and percentages
  always_ff @(posedge clk) begin
    if (s_accept) begin
      clr_r <= s_tdata[15:0];
      red_r <= s_tdata[31:16];
      grn_r <= s_tdata[47:32];
      blu_r <= s_tdata[63:48];
    end
    if (state == ST_SCALE) scale <= product[RECIP_SHIFT +: SCALE_W];
    if (state == ST_DIV_WAIT && div_rsp.done) pct[ch] <= div_rsp.quotient;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= '0;
    end else if (state == ST_SCALE) begin
      ch <= '0;
    end else if (state == ST_DIV_WAIT && div_rsp.done) begin
      ch <= ch + 2'd1;
    end
  end

  // Window tests, first match wins
  always_comb begin
    hit_idx = '0;
    any_hit = 1'b0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      hits[k] = (pct[0] > DIV_W'(WINDOWS[k].rlo)) && (pct[0] < DIV_W'(WINDOWS[k].rhi)) &&
                (pct[1] > DIV_W'(WINDOWS[k].glo)) && (pct[1] < DIV_W'(WINDOWS[k].ghi)) &&
                (pct[2] > DIV_W'(WINDOWS[k].blo)) && (pct[2] < DIV_W'(WINDOWS[k].bhi));
    end
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (hits[k]) begin
        hit_idx = 3'(k);
        any_hit = 1'b1;
      end
    end
  end

  // Class state update
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_count    <= '0;
      servo_position <= SERVO_DEFECT;
      led_r          <= LED_OFF;
      led_g          <= LED_OFF;
      led_b          <= LED_OFF;
      cat            <= CAT_GAP;
      adv            <= 1'b0;
      for (int i = 0; i < NUM_COUNTS; i++) counters[i] <= '0;
    end else if (s_accept) begin
      if (s_tuser[0]) begin
        for (int i = 0; i < NUM_COUNTS; i++) counters[i] <= '0;
        cat <= CAT_CLEARED;
        adv <= 1'b0;
      end else if (!present) begin
        led_r       <= LED_OFF;
        led_g       <= LED_OFF;
        led_b       <= LED_OFF;
        retry_count <= '0;
        cat         <= CAT_GAP;
        adv         <= 1'b1;
      end
    end else if (state == ST_MATCH) begin
      if (any_hit) begin
        servo_position    <= WINDOWS[hit_idx].servo;
        led_r             <= WINDOWS[hit_idx].dr;
        led_g             <= WINDOWS[hit_idx].dg;
        led_b             <= WINDOWS[hit_idx].db;
        counters[hit_idx] <= counters[hit_idx] + COUNTER_BITS'(1);
        retry_count       <= '0;
        cat               <= cat_t'({1'b0, hit_idx});
        adv               <= 1'b1;
      end else if (retry_count < retry_limit) begin
        retry_count <= retry_count + 8'd1;
        cat         <= CAT_RETRY;
        adv         <= 1'b0;
      end else begin
        servo_position <= SERVO_DEFECT;
        led_r          <= LED_FULL;
        led_g          <= LED_FULL;
        led_b          <= LED_FULL;
        counters[NUM_COUNTS-1] <= counters[NUM_COUNTS-1] + COUNTER_BITS'(1);
        retry_count    <= '0;
        cat            <= CAT_DEFECT;
        adv            <= 1'b1;
      end
    end
  end

  // Result word, highest field first
  assign word = {counters[5][7:0], counters[4][7:0], counters[3][7:0],
                 counters[2][7:0], counters[1][7:0], counters[0][7:0],
                 adv, led_b, led_g, led_r, servo_position};

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ld_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      m_tdata <= {3'b000, word};
      m_tuser <= cat;
    end
  end

  a_clear_zeroes : assert property (@(posedge clk) disable iff (rst)
      s_accept && s_tuser[0] |=> counters[0] == '0 && counters[1] == '0 &&
      counters[2] == '0 && counters[3] == '0 && counters[4] == '0 && counters[5] == '0)
    else $error("clear request left a counter nonzero");
  a_idle_div : assert property (@(posedge clk) disable iff (rst)
      s_tready |-> !div_rsp.busy)
    else $error("request taken while divider busy");
  a_no_advance : assert property (@(posedge clk) disable iff (rst)
      m_tvalid && (m_tuser == CAT_RETRY || m_tuser == CAT_CLEARED) |-> !m_tdata[28])
    else $error("advance set on retry or clear result");

endmodule
